// File: hw/rtl/mrnd_pkg.sv
// Shared constants, types and the notice header text for the receive-notice deframer.
`timescale 1ns / 1ps

package mrnd_pkg;

    localparam int MAX_PAYLOAD_DEF = 128;
    localparam int CHANNELS_DEF    = 2;

    localparam int BYTE_W    = 8;
    localparam int OUT_CH_W  = 2;
    localparam int CH_ID_W   = 4;
    localparam int HDR_LEN   = 9;
    localparam int HDR_IDX_W = 4;

    localparam int DIGIT_START  = 2;
    localparam int MIN_LINE_LEN = 5;

    localparam logic [BYTE_W-1:0] ASC_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] ASC_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] ASC_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] ASC_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] ASC_ONE   = 8'h31;
    localparam logic [BYTE_W-1:0] ASC_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] ASC_SPACE = 8'h20;

    typedef struct packed {
        logic [BYTE_W-1:0]   data_byte;
        logic [OUT_CH_W-1:0] channel;
        logic                last;
    } t_result;

    // Expected text of the header that follows the plus sign: "RECEIVE: ".
    function automatic logic [BYTE_W-1:0] hdr_char(input logic [HDR_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] c;
        unique case (idx)
            4'd0:    c = 8'h52;
            4'd1:    c = 8'h45;
            4'd2:    c = 8'h43;
            4'd3:    c = 8'h45;
            4'd4:    c = 8'h49;
            4'd5:    c = 8'h56;
            4'd6:    c = 8'h45;
            4'd7:    c = 8'h3A;
            default: c = ASC_SPACE;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/mrnd_in_reg.sv
// Input register that holds one received word until the parser takes it.
`timescale 1ns / 1ps

module mrnd_in_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [mrnd_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic                          i_adv,
    output logic                          o_stall,
    output logic                          o_valid,
    output logic [mrnd_pkg::BYTE_W-1:0]   o_byte
);

    logic                        r_valid;
    logic                        n_valid;
    logic [mrnd_pkg::BYTE_W-1:0] r_byte;
    logic                        accept;

    assign o_stall = r_valid && !i_adv;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_adv) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// File: hw/rtl/mrnd_parser.sv
// Notice parser: state update for one byte and the payload word it produces.
`timescale 1ns / 1ps

module mrnd_parser #(
    parameter int MAX_PAYLOAD = mrnd_pkg::MAX_PAYLOAD_DEF,
    parameter int CHANNELS    = mrnd_pkg::CHANNELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [mrnd_pkg::BYTE_W-1:0]   i_byte,
    output logic                          o_res_valid,
    output mrnd_pkg::t_result             o_res
);

    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = CW + 4;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_CHANNEL,
        PH_LENGTH,
        PH_DATA
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [CW-1:0]                   r_fc, n_fc;
    logic                            r_mis, n_mis;
    logic [mrnd_pkg::CH_ID_W-1:0]    r_ch, n_ch;
    logic [CW-1:0]                   r_acc, n_acc;
    logic                            r_dd, n_dd;
    logic                            r_cr, n_cr;
    logic [CW-1:0]                   r_plen, n_plen;

    logic [CW-1:0] fc_inc;
    logic [AW-1:0] acc_mul;
    logic          is_digit;
    logic          line_ends;
    logic          hdr_bad;

    assign fc_inc   = r_fc + 1'b1;
    assign is_digit = (i_byte >= mrnd_pkg::ASC_ZERO) && (i_byte <= mrnd_pkg::ASC_NINE);
    assign acc_mul  = AW'({r_acc, 3'b000}) + AW'({r_acc, 1'b0}) + AW'(i_byte[3:0]);
    assign hdr_bad  = i_byte != mrnd_pkg::hdr_char(r_fc[mrnd_pkg::HDR_IDX_W-1:0]);
    assign line_ends = (i_byte == mrnd_pkg::ASC_LF) && r_cr && (fc_inc > CW'(2));

    always_comb begin
        n_phase = r_phase;
        n_fc    = r_fc;
        n_mis   = r_mis;
        n_ch    = r_ch;
        n_acc   = r_acc;
        n_dd    = r_dd;
        n_cr    = r_cr;
        n_plen  = r_plen;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == mrnd_pkg::ASC_PLUS) begin
                    n_phase = PH_HEADER;
                    n_fc    = '0;
                    n_mis   = 1'b0;
                end
            end
            PH_HEADER: begin
                n_mis = r_mis || hdr_bad;
                n_fc  = fc_inc;
                if (fc_inc >= CW'(mrnd_pkg::HDR_LEN)) begin
                    if (n_mis) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_phase = PH_CHANNEL;
                        n_fc    = '0;
                    end
                end
            end
            PH_CHANNEL: begin
                if ((i_byte >= mrnd_pkg::ASC_ONE)
                        && (i_byte <= mrnd_pkg::ASC_ZERO + mrnd_pkg::BYTE_W'(CHANNELS))) begin
                    n_ch    = i_byte[mrnd_pkg::CH_ID_W-1:0];
                    n_phase = PH_LENGTH;
                    n_fc    = '0;
                    n_acc   = '0;
                    n_dd    = 1'b0;
                    n_cr    = 1'b0;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_LENGTH: begin
                if ((r_fc >= CW'(mrnd_pkg::DIGIT_START)) && !r_dd) begin
                    if (is_digit) begin
                        n_acc = (acc_mul >= AW'(MAX_PAYLOAD)) ? CW'(MAX_PAYLOAD)
                                                              : acc_mul[CW-1:0];
                    end else begin
                        n_dd = 1'b1;
                    end
                end
                n_fc = fc_inc;
                n_cr = i_byte == mrnd_pkg::ASC_CR;
                if (line_ends) begin
                    if ((fc_inc >= CW'(mrnd_pkg::MIN_LINE_LEN)) && (n_acc != '0)
                            && (n_acc < CW'(MAX_PAYLOAD))) begin
                        n_plen  = n_acc;
                        n_phase = PH_DATA;
                        n_fc    = '0;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end else if (fc_inc >= CW'(MAX_PAYLOAD)) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_DATA: begin
                n_fc = fc_inc;
                if (fc_inc >= r_plen) begin
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_fc    <= '0;
            r_mis   <= 1'b0;
            r_ch    <= '0;
            r_acc   <= '0;
            r_dd    <= 1'b0;
            r_cr    <= 1'b0;
            r_plen  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_fc    <= n_fc;
            r_mis   <= n_mis;
            r_ch    <= n_ch;
            r_acc   <= n_acc;
            r_dd    <= n_dd;
            r_cr    <= n_cr;
            r_plen  <= n_plen;
        end
    end

    assign o_res_valid     = r_phase == PH_DATA;
    assign o_res.data_byte = i_byte;
    assign o_res.channel   = r_ch[mrnd_pkg::OUT_CH_W-1:0];
    assign o_res.last      = fc_inc >= r_plen;

endmodule

// File: hw/rtl/modem_receive_notice_deframer_unit.sv
// Top level of the receive-notice deframer: input register, parser and result register.
`timescale 1ns / 1ps

// Takes one modem byte per clock and hunts for the notice "+RECEIVE: c, n" CR LF,
// then sends each of the n payload bytes out as a word carrying its channel and a
// last flag; malformed notices are dropped silently. A new byte is accepted in every
// cycle while the output side keeps up. Each accepted byte waits in the input
// register while the parser updates its state, and its payload word is then loaded
// into the result register when the result register is free or being emptied.
// While a finished word waits to be taken, the input register still accepts
// one further byte before the input stalls.

module modem_receive_notice_deframer_unit #(
    parameter int MAX_PAYLOAD = mrnd_pkg::MAX_PAYLOAD_DEF,
    parameter int CHANNELS    = mrnd_pkg::CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [mrnd_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [mrnd_pkg::BYTE_W-1:0]     o_data_byte,
    output logic [mrnd_pkg::OUT_CH_W-1:0]   o_channel,
    output logic                            o_last
);

    logic                        in_valid;
    logic [mrnd_pkg::BYTE_W-1:0] in_byte;
    logic                        adv;
    logic                        res_valid;
    mrnd_pkg::t_result           res;

    logic              r_out_valid;
    mrnd_pkg::t_result r_out;

    assign adv = in_valid && (!r_out_valid || !i_stall);

    mrnd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .i_adv     (adv),
        .o_stall   (o_stall),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    mrnd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .CHANNELS    (CHANNELS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (adv),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= res_valid;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (adv && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_data_byte = r_out.data_byte;
    assign o_channel   = r_out.channel;
    assign o_last      = r_out.last;

endmodule

// File: hw/rtl/mrnd_checker.sv
// Port-level checks for the receive-notice deframer, bound to the top level.
`timescale 1ns / 1ps

module mrnd_checker #(
    parameter int CHANNELS = mrnd_pkg::CHANNELS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [mrnd_pkg::BYTE_W-1:0]     o_data_byte,
    input logic [mrnd_pkg::OUT_CH_W-1:0]   o_channel,
    input logic                            o_last
);

    // A stalled output word is held unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data_byte) && $stable(o_channel)
            && $stable(o_last))
        else $error("output word changed while stalled");

    // Reset leaves no word pending on the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid directly after reset");

    // A word appearing on an empty output traces back to a byte taken by the input register.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) && $past(i_rst_n) && $past(i_rst_n, 2)
            |-> $past(i_valid && !o_stall, 2))
        else $error("output word without a matching accepted byte");

    // A channel taken from a notice is never zero while it fits the two output bits.
    a_channel_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (CHANNELS > 3) || (o_channel != '0))
        else $error("payload word carries channel zero");

endmodule

bind modem_receive_notice_deframer_unit mrnd_checker #(
    .CHANNELS (CHANNELS)
) u_mrnd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_data_byte (o_data_byte),
    .o_channel   (o_channel),
    .o_last      (o_last)
);

// File: tb/tb_modem_receive_notice_deframer_unit.sv
// Self-checking testbench for the modem receive-notice deframer.
`timescale 1ns / 1ps

module tb_modem_receive_notice_deframer_unit;

    import mrnd_pkg::*;

    localparam int MAX_PAY     = MAX_PAYLOAD_DEF;
    localparam int CHANS       = CHANNELS_DEF;
    localparam int HOLD_CYCLES = 64;

    typedef enum logic [2:0] {
        SEEK_PLUS,
        MATCH_TAG,
        READ_CHANNEL,
        READ_LENGTH,
        PASS_PAYLOAD
    } parse_phase_e;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                i_valid   = 1'b0;
    logic [BYTE_W-1:0]   i_rx_byte = '0;
    logic                i_stall   = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [BYTE_W-1:0]   o_data_byte;
    logic [OUT_CH_W-1:0] o_channel;
    logic                o_last;

    string notice_tag = "RECEIVE: ";

    parse_phase_e ph       = SEEK_PLUS;
    int           fcnt     = 0;
    bit           tag_bad  = 1'b0;
    logic [3:0]   chan_num = '0;
    int           len_acc  = 0;
    bit           len_done = 1'b0;
    bit           saw_cr   = 1'b0;
    int           pay_len  = 0;

    t_result expected_words[$];

    int errors         = 0;
    int bytes_sent     = 0;
    int parsed_bytes   = 0;
    int notices_framed = 0;
    int words_checked  = 0;
    int tx_idle_pct    = 9;
    int rx_idle_pct    = 9;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    modem_receive_notice_deframer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data_byte (o_data_byte),
        .o_channel   (o_channel),
        .o_last      (o_last)
    );

    always #2 i_clk = ~i_clk;

    // Tracks the notice parser for one accepted byte and queues any payload word.
    function automatic void track_byte(input logic [BYTE_W-1:0] b);
        int      v;
        bit      ends;
        bit      fin;
        t_result w;
        if (ph != SEEK_PLUS || b == ASC_PLUS) begin
            parsed_bytes++;
        end
        case (ph)
            SEEK_PLUS: begin
                if (b == ASC_PLUS) begin
                    ph      = MATCH_TAG;
                    fcnt    = 0;
                    tag_bad = 1'b0;
                end
            end
            MATCH_TAG: begin
                if (fcnt >= HDR_LEN || b != notice_tag[fcnt]) begin
                    tag_bad = 1'b1;
                end
                fcnt++;
                if (fcnt >= HDR_LEN) begin
                    if (tag_bad) begin
                        ph = SEEK_PLUS;
                    end else begin
                        ph   = READ_CHANNEL;
                        fcnt = 0;
                    end
                end
            end
            READ_CHANNEL: begin
                if (b >= ASC_ONE && b <= ASC_ZERO + CHANS) begin
                    chan_num = 4'(b - ASC_ZERO);
                    ph       = READ_LENGTH;
                    fcnt     = 0;
                    len_acc  = 0;
                    len_done = 1'b0;
                    saw_cr   = 1'b0;
                end else begin
                    ph = SEEK_PLUS;
                end
            end
            READ_LENGTH: begin
                if (fcnt >= DIGIT_START && !len_done) begin
                    if (b >= ASC_ZERO && b <= ASC_NINE) begin
                        v       = len_acc * 10 + int'(b - ASC_ZERO);
                        len_acc = (v >= MAX_PAY) ? MAX_PAY : v;
                    end else begin
                        len_done = 1'b1;
                    end
                end
                fcnt++;
                ends   = (b == ASC_LF) && saw_cr && fcnt > DIGIT_START;
                saw_cr = (b == ASC_CR);
                if (ends) begin
                    if (fcnt >= MIN_LINE_LEN && len_acc > 0 && len_acc < MAX_PAY) begin
                        pay_len = len_acc;
                        ph      = PASS_PAYLOAD;
                        fcnt    = 0;
                        notices_framed++;
                    end else begin
                        ph = SEEK_PLUS;
                    end
                end else if (fcnt >= MAX_PAY) begin
                    ph = SEEK_PLUS;
                end
            end
            PASS_PAYLOAD: begin
                fcnt++;
                fin         = (fcnt >= pay_len);
                w.data_byte = b;
                w.channel   = chan_num[OUT_CH_W-1:0];
                w.last      = fin;
                expected_words.push_back(w);
                if (fin) begin
                    ph = SEEK_PLUS;
                end
            end
            default: ph = SEEK_PLUS;
        endcase
    endfunction

    // Output side: checks each accepted word and drives the stall.
    always @(posedge i_clk) begin
        t_result w;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_words.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word: expected none, actual %h %0d %b",
                             $time, o_data_byte, o_channel, o_last);
                end else begin
                    w = expected_words.pop_front();
                    words_checked++;
                    if (o_data_byte !== w.data_byte) begin
                        errors++;
                        $display("%0t: data_byte mismatch: expected %h, actual %h",
                                 $time, w.data_byte, o_data_byte);
                    end
                    if (o_channel !== w.channel) begin
                        errors++;
                        $display("%0t: channel mismatch: expected %0d, actual %0d",
                                 $time, w.channel, o_channel);
                    end
                    if (o_last !== w.last) begin
                        errors++;
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, w.last, o_last);
                    end
                end
            end
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        track_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    task automatic send_crlf;
        send_byte(ASC_CR);
        send_byte(ASC_LF);
    endtask

    task automatic send_head(input logic [BYTE_W-1:0] ch, input logic [BYTE_W-1:0] s0,
                             input logic [BYTE_W-1:0] s1, input string digits);
        send_byte(ASC_PLUS);
        send_text(notice_tag);
        send_byte(ch);
        send_byte(s0);
        send_byte(s1);
        send_text(digits);
        send_crlf();
    endtask

    task automatic send_payload(input int n);
        repeat (n) send_byte(8'($urandom_range(255)));
    endtask

    task automatic send_notice(input int n);
        send_head(8'(ASC_ZERO + $urandom_range(1, CHANS)), ",", " ", $sformatf("%0d", n));
        send_payload(n);
    endtask

    task automatic test_extremes;
        send_head(ASC_ONE, ",", " ", "1");
        send_byte(8'h00);
        send_head(8'(ASC_ZERO + CHANS), ",", " ", "3");
        send_byte(8'hFF);
        send_byte(ASC_PLUS);
        send_byte(ASC_LF);
        send_head(ASC_ONE, ",", " ", "127");
        send_payload(MAX_PAY - 1);
    endtask

    task automatic test_header_faults;
        send_text("+RECE+IVE: 1, 2");
        send_crlf();
        send_text("+RECEIVX: 1, 2");
        send_crlf();
        send_notice(2);
    endtask

    task automatic test_channel_faults;
        send_head(ASC_ZERO, ",", " ", "2");
        send_head(8'(ASC_ZERO + CHANS + 1), ",", " ", "2");
        send_head(ASC_NINE, ",", " ", "2");
        send_head("A", ",", " ", "2");
        send_notice(1);
    endtask

    task automatic test_length_rules;
        send_byte(ASC_PLUS);
        send_text(notice_tag);
        send_byte(ASC_ONE);
        send_text(",5");
        send_crlf();
        send_head(ASC_ONE, ASC_CR, ASC_LF, "4");
        send_payload(4);
        send_head(ASC_ONE, ",", " ", "2x9");
        send_payload(2);
        send_head(ASC_ONE, ",", " ", "99999");
        send_head(ASC_ONE, ",", " ", "0");
        send_head(ASC_ONE, ",", " ", "128");
        send_head(8'(ASC_ZERO + CHANS), ",", " ", "007");
        send_payload(7);
    endtask

    task automatic test_long_line;
        send_byte(ASC_PLUS);
        send_text(notice_tag);
        send_byte(ASC_ONE);
        send_text(", 5");
        repeat (MAX_PAY) send_byte(8'($urandom_range(32, 126)));
        send_crlf();
        send_notice(3);
    endtask

    task automatic test_back_to_back;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (6) send_notice($urandom_range(1, 12));
        tx_idle_pct = 9;
        rx_idle_pct = 9;
    endtask

    task automatic test_backpressure;
        tx_idle_pct = 0;
        send_head(ASC_ONE, ",", " ", "40");
        hold_req++;
        send_payload(40);
        send_notice(5);
        tx_idle_pct = 9;
    endtask

    task automatic test_random;
        int          kind;
        int          n;
        int          pos;
        string       digits;
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] s0;
        logic [BYTE_W-1:0] s1;
        while (bytes_sent < 850) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                n = ($urandom_range(19) == 0) ? $urandom_range(9, MAX_PAY - 1)
                                              : $urandom_range(1, 8);
                digits = $sformatf("%0d", n);
                if ($urandom_range(4) == 0) begin
                    digits = {"0", digits};
                end
                s0 = ",";
                s1 = " ";
                if ($urandom_range(3) == 0) begin
                    s0 = 8'($urandom_range(255));
                    s1 = 8'($urandom_range(255));
                end
                send_head(8'(ASC_ZERO + $urandom_range(1, CHANS)), s0, s1, digits);
                send_payload(n);
            end else if (kind < 78) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
            end else if (kind < 86) begin
                pos = $urandom_range(HDR_LEN - 1);
                send_byte(ASC_PLUS);
                for (int i = 0; i < HDR_LEN; i++) begin
                    c = (i == pos) ? 8'($urandom_range(255)) : notice_tag[i];
                    send_byte(c);
                end
                send_byte(8'(ASC_ZERO + $urandom_range(1, CHANS)));
                send_text(", 3");
                send_crlf();
                send_payload(3);
            end else if (kind < 92) begin
                do c = 8'($urandom_range(255)); while (c >= ASC_ONE && c <= ASC_ZERO + CHANS);
                send_head(c, ",", " ", "2");
                send_payload(2);
            end else begin
                c = 8'(ASC_ZERO + $urandom_range(1, CHANS));
                case ($urandom_range(3))
                    0: send_head(c, ",", " ", "0");
                    1: send_head(c, ",", " ", $sformatf("%0d", $urandom_range(MAX_PAY, 99999)));
                    2: begin
                        send_byte(ASC_PLUS);
                        send_text(notice_tag);
                        send_byte(c);
                        send_text(",5");
                        send_crlf();
                    end
                    default: begin
                        send_byte(ASC_PLUS);
                        send_text(notice_tag);
                        send_byte(c);
                        repeat (MAX_PAY) send_byte(8'($urandom_range(32, 126)));
                    end
                endcase
                send_payload(2);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_header_faults();
        test_channel_faults();
        test_length_rules();
        test_long_line();
        test_back_to_back();
        test_backpressure();
        test_random();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("Sent %0d modem bytes, %0d of them inside notices; %0d notices framed.",
                 bytes_sent, parsed_bytes, notices_framed);
        $display("Checked %0d payload words under random idling and a long output hold.",
                 words_checked);
        if (errors == 0) begin
            $display("modem_receive_notice_deframer_unit verification clean");
        end else begin
            $display("modem_receive_notice_deframer_unit verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("modem_receive_notice_deframer_unit verification failed");
        $finish;
    end

endmodule
